// ===== design/bop_pkg.sv =====
// ----------------------------------------------------------------------------
// bop_pkg: shared types and constants of the best-offset prefetcher
// Line and address widths, register indexes, sequencer states, ALU request
// and response, and the published candidate offset list.
// ----------------------------------------------------------------------------
package bop_pkg;

    localparam int ADDR_W   = 48;            // byte address width of the ports
    localparam int LINE_OFF = 6;             // 64-byte line
    localparam int LINE_W   = ADDR_W - LINE_OFF;
    localparam int PAGE_W   = 6;             // lines per 4 KiB page, as bits
    localparam int SCORE_W  = 8;
    localparam int OFF_W    = 9;
    localparam int LIST_LEN = 52;

    // Configuration register indexes
    localparam logic [7:0] REG_MAX_SCORE  = 8'd0;
    localparam logic [7:0] REG_MAX_ROUNDS = 8'd1;
    localparam logic [7:0] REG_BAD_THRESH = 8'd2;

    // Input op codes
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_FILL   = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SUB,
        S_HASH,
        S_READ,
        S_CMP,
        S_FILL,
        S_RESULT
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [LINE_W-1:0] a;
        logic [LINE_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [LINE_W-1:0] res;
        logic              carry;
        logic              zero;
    } alu_rsp_t;

    localparam logic [OFF_W-1:0] OFFSET_LIST [LIST_LEN] = '{
        9'd1,   9'd2,   9'd3,   9'd4,   9'd5,   9'd6,   9'd8,   9'd9,
        9'd10,  9'd12,  9'd15,  9'd16,  9'd18,  9'd20,  9'd24,  9'd25,
        9'd27,  9'd30,  9'd32,  9'd36,  9'd40,  9'd45,  9'd48,  9'd50,
        9'd54,  9'd60,  9'd64,  9'd72,  9'd75,  9'd80,  9'd81,  9'd90,
        9'd96,  9'd100, 9'd108, 9'd120, 9'd125, 9'd128, 9'd135, 9'd144,
        9'd150, 9'd160, 9'd162, 9'd180, 9'd192, 9'd200, 9'd216, 9'd225,
        9'd240, 9'd243, 9'd250, 9'd256
    };

    function automatic logic [OFF_W-1:0] offset_of(input logic [5:0] idx);
        logic [OFF_W-1:0] val;
        if (idx < 6'(LIST_LEN)) begin
            val = OFFSET_LIST[idx];
        end else begin
            val = OFFSET_LIST[0];
        end
        return val;
    endfunction

endpackage

// ===== design/best_offset_prefetcher_core.sv =====
// ----------------------------------------------------------------------------
// best_offset_prefetcher_core: best-offset prefetcher, one item at a time
//
// Input channel (s_valid/s_ready): one beat per cache event. s_op selects a
// demand access or a cache fill; s_byte_address is the physical address.
// Result channel (m_valid/m_ready): exactly one beat per input beat, in
// order. m_prefetch_valid flags a prefetch; m_prefetch_address is the line
// address of it, zero when no prefetch is issued.
// Configuration channel (cfg_valid/cfg_ready): always ready. cfg_index picks
// the saturation score (0), the round budget (1) or the enable threshold (2);
// other indexes are dropped. Write only while no item is in flight.
//
// Sequencing: a small sequencer drives one shared adder (subtract, tag
// compare, target add) and the table index unit. An access runs accept,
// subtract, index, table read, score update, result; a fill runs accept,
// index, table write, result. When RR_ENTRIES is not a power of two the
// index unit reduces one byte a cycle. A new beat is taken only once the
// previous result has been loaded into the output register.
// Reset: the recent-request table is swept clear, one entry a cycle, with
// s_ready low. A stalled result holds in the output register; the next beat
// is accepted meanwhile and waits in the last step.
// ----------------------------------------------------------------------------
module best_offset_prefetcher_core
    import bop_pkg::*;
#(
    parameter int RR_ENTRIES  = 256,
    parameter int NUM_OFFSETS = 52,
    parameter int ADDR_BITS   = 48
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input item
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    input  logic [ADDR_W-1:0] s_byte_address,
    // result item
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_prefetch_valid,
    output logic [ADDR_W-1:0] m_prefetch_address,
    // configuration writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic [7:0]        cfg_data
);

    // Offsets beyond the published list are not used.
    localparam int ACTIVE   = (NUM_OFFSETS < LIST_LEN) ? NUM_OFFSETS : LIST_LEN;
    localparam int CAND_W   = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
    localparam int IDX_W    = $clog2(RR_ENTRIES);
    localparam int ADDR_EFF = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - ADDR_EFF);
    localparam logic [CAND_W-1:0] LAST_CAND = CAND_W'(ACTIVE - 1);
    localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(RR_ENTRIES - 1);

    // Sequencer
    state_t state_reg, state_next;

    // Configuration
    logic [SCORE_W-1:0] score_cap_reg;
    logic [7:0]         round_cap_reg;
    logic [SCORE_W-1:0] thresh_reg;

    // Learning state
    logic [CAND_W-1:0]  cand_reg, cand_next;
    logic [7:0]         round_reg, round_next;
    logic [SCORE_W-1:0] top_reg, top_next;
    logic [CAND_W-1:0]  best_idx_reg, best_idx_next;
    logic [ACTIVE-1:0]  score_vld_reg, score_vld_next;
    logic [OFF_W-1:0]   best_off_reg, best_off_next;
    logic               pf_en_reg, pf_en_next;

    // Item in flight
    logic               op_reg;
    logic [LINE_W-1:0]  line_reg;
    logic [LINE_W-1:0]  key_reg;
    logic               borrow_reg;
    logic [IDX_W-1:0]   clr_cnt_reg;

    // Output register
    logic               m_valid_reg;
    logic               m_pf_valid_reg;
    logic [ADDR_W-1:0]  m_pf_addr_reg;

    // Datapath wiring
    alu_req_t              alu_req;
    alu_rsp_t              alu_rsp;
    logic                  hash_req;
    logic                  hash_done;
    logic [IDX_W-1:0]      hash_slot;
    logic                  tab_we;
    logic                  tab_re;
    logic [IDX_W-1:0]      tab_waddr;
    logic [LINE_W:0]       tab_wdata;
    logic [LINE_W:0]       tab_rdata;
    logic                  score_re;
    logic                  score_we;
    logic [SCORE_W-1:0]    score_rdata;
    logic [SCORE_W-1:0]    score_cur;
    logic [SCORE_W-1:0]    score_new;
    logic [SCORE_W-1:0]    top_upd;
    logic [CAND_W-1:0]     best_upd;
    logic [7:0]            round_adv;
    logic [CAND_W-1:0]     cand_adv;
    logic                  hit;
    logic                  inc;
    logic                  phase_close;
    logic                  out_free;
    logic                  load_out;
    logic                  res_valid;
    logic [ADDR_W-1:0]     res_addr;
    logic [ADDR_W-1:0]     addr_masked;
    logic [OFF_W-1:0]      cand_off;

    assign addr_masked = s_byte_address & ADDR_MASK;
    assign cand_off    = offset_of(6'(cand_reg));
    assign out_free    = !m_valid_reg || m_ready;
    assign cfg_ready   = 1'b1;

    // ---------------------------------------------------------------- units
    bop_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    bop_hash #(
        .RR_ENTRIES (RR_ENTRIES)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (hash_req),
        .key     (key_reg),
        .done    (hash_done),
        .slot    (hash_slot)
    );

    // Recent-request table: valid bit on top of the line number.
    bop_ram #(
        .WIDTH (LINE_W + 1),
        .DEPTH (RR_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .re    (tab_re),
        .raddr (hash_slot),
        .rdata (tab_rdata)
    );

    // Candidate scores; an entry reads as zero until its valid bit is set.
    bop_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (ACTIVE)
    ) u_scores (
        .aclk  (aclk),
        .we    (score_we),
        .waddr (cand_reg),
        .wdata (score_new),
        .re    (score_re),
        .raddr (cand_reg),
        .rdata (score_rdata)
    );

    // --------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_cnt_reg == LAST_SLOT) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = (s_op == OP_FILL) ? S_HASH : S_SUB;
                end
            end
            S_SUB:    state_next = S_HASH;
            S_HASH: begin
                if (hash_done) begin
                    state_next = (op_reg == OP_FILL) ? S_FILL : S_READ;
                end
            end
            S_READ:   state_next = S_CMP;
            S_CMP:    state_next = S_RESULT;
            S_FILL:   state_next = S_RESULT;
            S_RESULT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_CLEAR;
        endcase
    end

    // ------------------------------------------------------ step controls
    always_comb begin
        s_ready   = 1'b0;
        hash_req  = 1'b0;
        tab_we    = 1'b0;
        tab_re    = 1'b0;
        tab_waddr = hash_slot;
        tab_wdata = {1'b1, line_reg};
        score_re  = 1'b0;
        load_out  = 1'b0;
        alu_req.op = ALU_SUB;
        alu_req.a  = line_reg;
        alu_req.b  = LINE_W'(cand_off);
        unique case (state_reg)
            S_CLEAR: begin
                tab_we    = 1'b1;
                tab_waddr = clr_cnt_reg;
                tab_wdata = '0;
            end
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_SUB: begin
                // line minus candidate offset; score entry fetched alongside
                score_re = 1'b1;
            end
            S_HASH: begin
                hash_req = 1'b1;
            end
            S_READ: begin
                tab_re = 1'b1;
            end
            S_CMP: begin
                // tag compare against the looked-up line
                alu_req.a = tab_rdata[LINE_W-1:0];
                alu_req.b = key_reg;
            end
            S_FILL: begin
                tab_we = 1'b1;
            end
            S_RESULT: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = LINE_W'(line_reg[PAGE_W-1:0]);
                alu_req.b  = LINE_W'(best_off_reg);
                load_out   = out_free;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------- score update
    always_comb begin
        score_cur = score_vld_reg[cand_reg] ? score_rdata : '0;
        hit       = !borrow_reg && tab_rdata[LINE_W] && alu_rsp.zero;
        inc       = hit && (score_cur < score_cap_reg);
        score_new = score_cur + 1'b1;
        score_we  = (state_reg == S_CMP) && inc;

        // Track the first highest score as scores climb.
        top_upd  = top_reg;
        best_upd = best_idx_reg;
        if (inc && ((score_new > top_reg) ||
                    ((score_new == top_reg) && (cand_reg < best_idx_reg)))) begin
            top_upd  = score_new;
            best_upd = cand_reg;
        end

        cand_adv    = (cand_reg == LAST_CAND) ? '0 : cand_reg + 1'b1;
        round_adv   = (cand_reg == LAST_CAND) ? round_reg + 8'd1 : round_reg;
        phase_close = (round_adv >= round_cap_reg) || (top_upd >= score_cap_reg);

        cand_next      = cand_reg;
        round_next     = round_reg;
        top_next       = top_reg;
        best_idx_next  = best_idx_reg;
        score_vld_next = score_vld_reg;
        best_off_next  = best_off_reg;
        pf_en_next     = pf_en_reg;
        if (state_reg == S_CMP) begin
            if (phase_close) begin
                // Close the phase: pick the winner, drop all scores.
                best_off_next  = offset_of(6'(best_upd));
                pf_en_next     = (top_upd > thresh_reg);
                cand_next      = '0;
                round_next     = '0;
                top_next       = '0;
                best_idx_next  = '0;
                score_vld_next = '0;
            end else begin
                cand_next     = cand_adv;
                round_next    = round_adv;
                top_next      = top_upd;
                best_idx_next = best_upd;
                if (inc) begin
                    score_vld_next[cand_reg] = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------- result
    always_comb begin
        res_valid = (op_reg == OP_ACCESS) && pf_en_reg &&
                    (alu_rsp.res[LINE_W-1:PAGE_W] == '0);
        res_addr  = '0;
        if (res_valid) begin
            res_addr = {line_reg[LINE_W-1:PAGE_W], alu_rsp.res[PAGE_W-1:0],
                        {LINE_OFF{1'b0}}};
        end
    end

    // ---------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            score_cap_reg  <= 8'd31;
            round_cap_reg  <= 8'd100;
            thresh_reg     <= 8'd1;
            cand_reg       <= '0;
            round_reg      <= '0;
            top_reg        <= '0;
            best_idx_reg   <= '0;
            score_vld_reg  <= '0;
            best_off_reg   <= OFF_W'(1);
            pf_en_reg      <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cand_reg      <= cand_next;
            round_reg     <= round_next;
            top_reg       <= top_next;
            best_idx_reg  <= best_idx_next;
            score_vld_reg <= score_vld_next;
            best_off_reg  <= best_off_next;
            pf_en_reg     <= pf_en_next;
            if (state_reg == S_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_MAX_SCORE:  score_cap_reg <= cfg_data;
                    REG_MAX_ROUNDS: round_cap_reg <= cfg_data;
                    REG_BAD_THRESH: thresh_reg    <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_op;
            line_reg <= addr_masked[ADDR_W-1:LINE_OFF];
            key_reg  <= addr_masked[ADDR_W-1:LINE_OFF];
        end
        if (state_reg == S_SUB) begin
            key_reg    <= alu_rsp.res;
            borrow_reg <= !alu_rsp.carry;
        end
        if (load_out) begin
            m_pf_valid_reg <= res_valid;
            m_pf_addr_reg  <= res_addr;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_prefetch_valid   = m_pf_valid_reg;
    assign m_prefetch_address = m_pf_addr_reg;

    // --------------------------------------------------------- assertions
    a_phase_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP && phase_close) |=> (top_reg == '0 && score_vld_reg == '0))
        else $error("scores not cleared at phase end");

    a_cand_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cand_reg <= LAST_CAND)
        else $error("candidate index out of range");

    a_best_scored: assert property (@(posedge aclk) disable iff (!aresetn)
        (top_reg != '0) |-> score_vld_reg[best_idx_reg])
        else $error("best candidate has no score");

    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESULT && out_free) |=> m_valid)
        else $error("result beat not presented");

endmodule

// ===== design/bop_ram.sv =====
// ----------------------------------------------------------------------------
// bop_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bop_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bop_alu.sv =====
// ----------------------------------------------------------------------------
// bop_alu: shared line-width adder / subtractor
// Serves the candidate subtract, the tag compare and the target add.
// ----------------------------------------------------------------------------
module bop_alu
    import bop_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [LINE_W-1:0] b_eff;
    logic [LINE_W:0]   sum;

    always_comb begin
        b_eff     = (req.op == ALU_SUB) ? ~req.b : req.b;
        sum       = {1'b0, req.a} + {1'b0, b_eff} + (LINE_W + 1)'(req.op == ALU_SUB);
        rsp.res   = sum[LINE_W-1:0];
        rsp.carry = sum[LINE_W];
        rsp.zero  = (sum[LINE_W-1:0] == '0);
    end

endmodule

// ===== design/bop_hash.sv =====
// ----------------------------------------------------------------------------
// bop_hash: recent-request table index
// Xor-fold the line, then reduce modulo the table size: a mask for a power
// of two, otherwise one byte a cycle from the top through a remainder loop.
// ----------------------------------------------------------------------------
module bop_hash
    import bop_pkg::*;
#(
    parameter int RR_ENTRIES = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          req,
    input  logic [LINE_W-1:0]             key,
    output logic                          done,
    output logic [$clog2(RR_ENTRIES)-1:0] slot
);

    localparam int IDX_W   = $clog2(RR_ENTRIES);
    localparam bit IS_POW2 = ((1 << IDX_W) == RR_ENTRIES);
    localparam int BYTES   = (LINE_W + 7) / 8;
    localparam int PAD_W   = BYTES * 8;
    localparam int CHUNKS  = IS_POW2 ? 1 : BYTES;
    localparam int CNT_W   = $clog2(BYTES);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              last;
    logic [LINE_W-1:0] fold1, fold;
    logic [IDX_W-1:0]  slot_reg;

    always_comb begin
        fold1 = key ^ (key >> 16);
        fold  = fold1 ^ (fold1 >> 8);
    end

    assign last = (cnt_reg == CNT_W'(CHUNKS - 1));
    assign done = req && last;

    always_comb begin
        cnt_next = cnt_reg;
        if (req) begin
            cnt_next = last ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    generate
        if (IS_POW2) begin : g_mask
            always_ff @(posedge aclk) begin
                if (req) begin
                    slot_reg <= fold[IDX_W-1:0];
                end
            end
        end else begin : g_mod
            localparam int RW = IDX_W + 8;

            function automatic logic [IDX_W-1:0] mod_step(input logic [RW-1:0] x);
                logic [RW-1:0] v;
                v = x;
                for (int k = 7; k >= 0; k--) begin
                    if (v >= (RW'(RR_ENTRIES) << k)) begin
                        v = v - (RW'(RR_ENTRIES) << k);
                    end
                end
                return v[IDX_W-1:0];
            endfunction

            logic [IDX_W-1:0] rem_reg;
            logic [IDX_W-1:0] rem_next;
            logic [PAD_W-1:0] padded;
            logic [CNT_W-1:0] sel;
            logic [7:0]       chunk;

            always_comb begin
                padded   = PAD_W'(fold);
                sel      = CNT_W'(CHUNKS - 1) - cnt_reg;
                chunk    = padded[int'(sel) * 8 +: 8];
                rem_next = mod_step({rem_reg, chunk});
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    rem_reg <= '0;
                end else if (req) begin
                    rem_reg <= last ? '0 : rem_next;
                end
            end

            always_ff @(posedge aclk) begin
                if (req && last) begin
                    slot_reg <= rem_next;
                end
            end
        end
    endgenerate

    assign slot = slot_reg;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for best_offset_prefetcher_core
// Streams of demand accesses and fills train the offset learner under several
// register settings. A behavioral model predicts the prefetch of every beat,
// and a monitor compares each result beat in order against that prediction.
// ----------------------------------------------------------------------------
module tb_top
    import bop_pkg::*;
();

    localparam int CYCLE_LIMIT = 300000;  // far above the slowest legal run
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS = 60;
    localparam int PHASES = 9;
    localparam int TABLE_SLOTS = 256;
    localparam int CAND_COUNT = 52;

    // indexes outside the register map; writes to them must be dropped
    localparam logic [7:0] REG_UNMAPPED = 8'd3;
    localparam logic [7:0] REG_TOP_INDEX = 8'hFF;

    // candidate offsets in round-robin order (2^i * 3^j * 5^k up to 256)
    localparam int CANDIDATES [CAND_COUNT] = '{
        1, 2, 3, 4, 5, 6, 8, 9, 10, 12, 15, 16, 18, 20, 24, 25, 27, 30,
        32, 36, 40, 45, 48, 50, 54, 60, 64, 72, 75, 80, 81, 90, 96, 100,
        108, 120, 125, 128, 135, 144, 150, 160, 162, 180, 192, 200, 216,
        225, 240, 243, 250, 256};

    // register settings of the random phases, extremes included
    localparam int PLAN_SCORE  [PHASES] = '{2, 255, 3, 1, 255, 5, 6, 31, 4};
    localparam int PLAN_ROUNDS [PHASES] = '{1, 255, 2, 1, 1, 3, 255, 100, 2};
    localparam int PLAN_THRESH [PHASES] = '{0, 254, 1, 0, 0, 2, 2, 1, 3};

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
    } cache_event_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
    } prefetch_t;

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_op = OP_ACCESS;
    logic [ADDR_W-1:0] s_byte_address = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_prefetch_valid;
    logic [ADDR_W-1:0] m_prefetch_address;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [7:0]        cfg_index = '0;
    logic [7:0]        cfg_data = '0;

    best_offset_prefetcher_core uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_byte_address     (s_byte_address),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_prefetch_valid   (m_prefetch_valid),
        .m_prefetch_address (m_prefetch_address),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    cache_event_t cache_events [$];   // beats still to be driven
    prefetch_t    prefetch_due [$];   // predicted results, oldest first
    int           src_idle_pct = 0;
    int           snk_idle_pct = 0;
    int           mismatches = 0;
    int           beats_seen = 0;
    int           cycle_count = 0;

    // Model of the learner: register copies and its own learning state
    bit [7:0]  cap_score = 8'd31;
    bit [7:0]  cap_rounds = 8'd100;
    bit [7:0]  bad_thresh = 8'd1;
    bit [41:0] rr_line [TABLE_SLOTS];
    bit        rr_valid [TABLE_SLOTS];
    bit [7:0]  scores [CAND_COUNT];
    bit [7:0]  rounds = '0;
    int        cand_ptr = 0;
    int        best_off = 1;
    bit        pf_enable = 1'b1;

    // xor-fold the line number down to a table slot
    function automatic logic [7:0] slot_of(input logic [63:0] line);
        logic [63:0] h;
        h = line;
        h ^= h >> 16;
        h ^= h >> 8;
        return h[7:0];
    endfunction

    // Advance the model by one accepted beat and return its prefetch.
    task automatic advance_prefetcher(input cache_event_t ev, output prefetch_t res);
        logic [63:0] line;
        logic [63:0] probe;
        logic [63:0] target;
        logic [7:0]  slot;
        int          top;
        int          pick;
        bit          closing;
        res = '0;
        line = 64'(ev.addr >> LINE_OFF);
        if (ev.op == OP_FILL) begin
            // record the filled line; fills never prefetch
            slot = slot_of(line);
            rr_line[slot] = line[41:0];
            rr_valid[slot] = 1'b1;
        end else begin
            // score the current candidate if line - offset was filled recently;
            // a line below the offset is never scored
            if (line >= 64'(CANDIDATES[cand_ptr])) begin
                probe = line - 64'(CANDIDATES[cand_ptr]);
                slot = slot_of(probe);
                if (rr_valid[slot] && rr_line[slot] == probe[41:0]
                        && scores[cand_ptr] < cap_score) begin
                    scores[cand_ptr]++;
                end
            end
            cand_ptr++;
            if (cand_ptr >= CAND_COUNT) begin
                cand_ptr = 0;
                rounds++;
            end
            // learning phase ends on round budget or on any saturated score
            closing = rounds >= cap_rounds;
            foreach (scores[i]) begin
                if (scores[i] >= cap_score) begin
                    closing = 1'b1;
                end
            end
            if (closing) begin
                // first highest score wins; all zero falls back to offset 1
                top = 0;
                pick = 0;
                foreach (scores[i]) begin
                    if (int'(scores[i]) > top) begin
                        top = int'(scores[i]);
                        pick = i;
                    end
                end
                best_off = CANDIDATES[pick];
                pf_enable = top > int'(bad_thresh);
                foreach (scores[i]) begin
                    scores[i] = '0;
                end
                rounds = '0;
                cand_ptr = 0;
            end
            // issue line + best offset only inside the same 4 KiB page
            if (pf_enable) begin
                target = line + 64'(best_off);
                if ((target >> PAGE_W) == (line >> PAGE_W)) begin
                    res.valid = 1'b1;
                    res.addr = ADDR_W'(target << LINE_OFF);
                end
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                 input logic [ADDR_W-1:0] want);
        $display("ERROR t=%0t beat %0d: %s got %h want %h",
                 $time, beats_seen, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: predict each accepted beat, then present the next queued one
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        cache_event_t cur;
        cache_event_t nxt;
        prefetch_t    res;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                cur.op = s_op;
                cur.addr = s_byte_address;
                advance_prefetcher(cur, res);
                prefetch_due.push_back(res);
            end
            // hold the beat until it is taken; otherwise load or idle
            if (!s_valid || s_ready) begin
                if (cache_events.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt = cache_events.pop_front();
                    s_valid <= 1'b1;
                    s_op <= nxt.op;
                    s_byte_address <= nxt.addr;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each result beat with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        prefetch_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                beats_seen++;
                if (prefetch_due.size() == 0) begin
                    flag_mismatch("unexpected result beat", m_prefetch_address, '0);
                end else begin
                    want = prefetch_due.pop_front();
                    if (m_prefetch_valid !== want.valid) begin
                        flag_mismatch("prefetch_valid", ADDR_W'(m_prefetch_valid),
                                      ADDR_W'(want.valid));
                    end
                    if (m_prefetch_address !== want.addr) begin
                        flag_mismatch("prefetch_address", m_prefetch_address, want.addr);
                    end
                end
            end
            // stall the result channel at the current rate
            m_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Watchdog: a hung handshake ends the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Wait until every queued beat went in and every prediction came back.
    task automatic settle();
        do begin
            @(negedge aclk);
        end while (cache_events.size() != 0 || s_valid || prefetch_due.size() != 0);
    endtask

    // One register write beat; the model takes the value at the accepting edge.
    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        case (idx)
            REG_MAX_SCORE:  cap_score = val;
            REG_MAX_ROUNDS: cap_rounds = val;
            REG_BAD_THRESH: bad_thresh = val;
            default: ;  // drop writes outside the map
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Queue a beat for a line, with random byte offset inside the line.
    task automatic push_line(input logic op, input logic [41:0] line);
        cache_event_t ev;
        ev.op = op;
        ev.addr = {line, 6'($urandom_range(63))};
        cache_events.push_back(ev);
    endtask

    task automatic push_raw(input logic op, input logic [ADDR_W-1:0] addr);
        cache_event_t ev;
        ev.op = op;
        ev.addr = addr;
        cache_events.push_back(ev);
    endtask

    // Mostly strided streams (access then fill of each line) so that the
    // learner finds a winning offset; the rest is random noise. A fill is
    // dropped now and then to break a stream. Exactly count beats are queued.
    task automatic gen_traffic(input int count);
        int        n;
        int        pairs;
        int        stride;
        logic [41:0] base;
        logic [41:0] ln;
        n = 0;
        while (n < count) begin
            if ($urandom_range(99) < 75) begin
                if ($urandom_range(3) == 0) begin
                    stride = CANDIDATES[$urandom_range(CAND_COUNT - 1)];
                end else begin
                    stride = CANDIDATES[$urandom_range(11)];
                end
                case ($urandom_range(9))
                    0: base = 42'($urandom_range(40));          // lines below the offsets
                    1: base = '1 - 42'($urandom_range(600));     // top of the address space
                    default: base = 42'({$urandom, $urandom});
                endcase
                pairs = $urandom_range(24, 6);
                for (int k = 0; k < pairs && n < count; k++) begin
                    ln = base + 42'(k * stride);
                    push_line(OP_ACCESS, ln);
                    n++;
                    if ($urandom_range(9) != 0 && n < count) begin
                        push_line(OP_FILL, ln);
                        n++;
                    end
                end
            end else begin
                push_raw(1'($urandom_range(1)), ADDR_W'({$urandom, $urandom}));
                n++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed beats under the reset settings, first idling mix
        @(negedge aclk);
        src_idle_pct = 29;
        snk_idle_pct = 51;
        push_raw(OP_ACCESS, 48'h0);                // line below offset, prefetch line 1
        push_raw(OP_FILL, 48'hFFFF_FFFF_FFFF);
        push_raw(OP_ACCESS, 48'hFFFF_FFFF_FFFF);   // target crosses the page
        push_raw(OP_ACCESS, 48'hFFFF_FFFF_FFBF);   // last line that stays in page
        push_raw(OP_FILL, 48'h0000_0000_0040);
        push_raw(OP_ACCESS, 48'h0000_0000_0140);   // line 5 - offset 4 hits line 1
        push_raw(OP_FILL, 48'hAAAA_AAAA_AAAA);
        push_raw(OP_ACCESS, 48'h5555_5555_5555);
        push_raw(OP_FILL, 48'h5555_5555_5555);
        push_raw(OP_ACCESS, 48'hAAAA_AAAA_AAAA);
        settle();

        // zero saturation score: every access closes a phase, never enabled;
        // writes outside the register map must change nothing
        write_reg(REG_MAX_SCORE, 8'd0);
        write_reg(REG_UNMAPPED, 8'h7F);
        write_reg(REG_TOP_INDEX, 8'h00);
        @(negedge aclk);
        push_line(OP_FILL, 42'd200);
        push_line(OP_ACCESS, 42'd201);
        push_line(OP_ACCESS, 42'd202);
        settle();

        // zero round budget: one hit enables offset 1, a miss disables again
        write_reg(REG_MAX_SCORE, 8'd31);
        write_reg(REG_MAX_ROUNDS, 8'd0);
        write_reg(REG_BAD_THRESH, 8'd0);
        @(negedge aclk);
        push_line(OP_FILL, 42'd100);
        push_line(OP_ACCESS, 42'd101);
        push_line(OP_ACCESS, 42'd300);
        push_line(OP_ACCESS, 42'd400);
        settle();

        // random phases: three per idling mix, registers rewritten each time
        for (int p = 0; p < PHASES; p++) begin
            write_reg(REG_MAX_SCORE, 8'(PLAN_SCORE[p]));
            write_reg(REG_MAX_ROUNDS, 8'(PLAN_ROUNDS[p]));
            write_reg(REG_BAD_THRESH, 8'(PLAN_THRESH[p]));
            @(negedge aclk);
            if (p < 3) begin
                src_idle_pct = 29;
                snk_idle_pct = 51;
            end else if (p < 6) begin
                src_idle_pct = 51;
                snk_idle_pct = 29;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            gen_traffic(PHASE_ITEMS);
            settle();
        end

        // let any trailing activity show up before judging
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
